[src/ffira_pkg.sv]
// ----------------------------------------------------------------------------
// ffira_pkg
// Shared types and codes for the first-fit interval room allocator.
// ----------------------------------------------------------------------------
package ffira_pkg;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   // Result status codes.
   localparam logic [1:0] STAT_BOOKED  = 2'd0;
   localparam logic [1:0] STAT_OVERLAP = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_UNUSED  = 2'd3;

   // Fixed field widths of the item formats.
   localparam int FIELD_TIME_W = 16;
   localparam int CFG_W        = 3;
   localparam logic [CFG_W-1:0] ROOMS_RESET = 3'd4;

endpackage

[src/first_fit_interval_room_allocator.sv]
// Sequence: ST_SCAN walks every slot, ST_DRAIN waits for the last read, and
// ST_DECIDE books and responds once the output register is free. The slot walk
// reads one slot of every room per cycle via each room's single memory read port.
// The block takes no new item until the current response is loaded.
// Synchronous active-high reset empties every calendar and sets the room
// count to four; no clearing pass is needed.
// ----------------------------------------------------------------------------
// first_fit_interval_room_allocator
// Books half-open intervals into the first room without overlap and a free slot.
// ----------------------------------------------------------------------------
module first_fit_interval_room_allocator
   import ffira_pkg::*;
#(
   parameter int ROOMS     = 4,
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel. tdata: start_time [15:0], end_time [31:16].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Response channel. tdata: status [1:0], room_index [3:2], zero [7:4].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // Room count register.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam int TW      = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int RIDX_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;
   localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOTS - 1);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]   rooms_ff;
   logic [TW-1:0]      s_ff, e_ff;
   logic [SLOT_AW-1:0] addr_ff, addr_in;
   logic               rd_vld_ff;
   logic [SLOT_AW-1:0] rd_idx_ff;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]         rsp_tdata_ff;

   logic               accept;
   logic               scan_active;
   logic               commit;
   logic [ROOMS-1:0]   room_en;
   logic [ROOMS-1:0]   conf_vec;
   logic [ROOMS-1:0]   full_vec;
   logic [ROOMS-1:0]   wr_vec;
   logic               found;
   logic               full_free;
   logic [RIDX_W-1:0]  pick_idx;
   logic [1:0]         status_sel;

   assign accept      = req_tvalid && req_tready;
   assign scan_active = (state_ff == ST_SCAN);

   // Room count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rooms_ff <= ROOMS_RESET;
      end else if (csr_wr_en) begin
         rooms_ff <= csr_wr_data;
      end
   end

   // Request capture, masked to the stored time width.
   always_ff @(posedge clock) begin
      if (accept) begin
         s_ff <= req_tdata[TW-1:0];
         e_ff <= req_tdata[FIELD_TIME_W+TW-1:FIELD_TIME_W];
      end
   end

   // Read pipeline tags: which slot the registered read data belongs to.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= scan_active;
      end
      rd_idx_ff <= addr_ff;
   end

   // Per-room calendar: memories, fill count, read port and conflict flag.
   for (genvar r = 0; r < ROOMS; r++) begin : g_room
      logic [TW-1:0]    start_mem [SLOTS];
      logic [TW-1:0]    end_mem   [SLOTS];
      logic [TW-1:0]    rd_start_ff, rd_end_ff;
      logic [CNT_W-1:0] used_ff;
      logic             conf_ff;
      logic             hit;

      // A room takes part when its index is below the room count; room 0 always does.
      assign room_en[r]  = (r == 0) ? 1'b1 : ({29'd0, rooms_ff} > 32'(r));
      assign full_vec[r] = (used_ff == CNT_W'(SLOTS));
      assign conf_vec[r] = conf_ff;

      // Memory write on commit, memory read during the slot walk.
      always_ff @(posedge clock) begin
         if (wr_vec[r]) begin
            start_mem[used_ff[SLOT_AW-1:0]] <= s_ff;
            end_mem[used_ff[SLOT_AW-1:0]]   <= e_ff;
         end
         if (scan_active) begin
            rd_start_ff <= start_mem[addr_ff];
            rd_end_ff   <= end_mem[addr_ff];
         end
      end

      // Overlap test for the slot just read; only filled slots count.
      assign hit = rd_vld_ff && (CNT_W'(rd_idx_ff) < used_ff)
                   && (rd_start_ff < e_ff) && (s_ff < rd_end_ff);

      // Fill count and sticky conflict flag.
      always_ff @(posedge clock) begin
         if (reset) begin
            used_ff <= '0;
            conf_ff <= 1'b0;
         end else begin
            if (wr_vec[r]) begin
               used_ff <= used_ff + CNT_W'(1);
            end
            if (accept) begin
               conf_ff <= 1'b0;
            end else if (hit) begin
               conf_ff <= 1'b1;
            end
         end
      end
   end

   // First-fit choice over the enabled rooms; the lowest index wins.
   always_comb begin
      found     = 1'b0;
      full_free = 1'b0;
      pick_idx  = '0;
      wr_vec    = '0;
      for (int r = ROOMS - 1; r >= 0; r--) begin
         if (room_en[r] && !conf_vec[r]) begin
            if (full_vec[r]) begin
               full_free = 1'b1;
            end else begin
               found    = 1'b1;
               pick_idx = RIDX_W'(r);
            end
         end
      end
      for (int r = 0; r < ROOMS; r++) begin
         wr_vec[r] = commit && found && (pick_idx == RIDX_W'(r))
                     && room_en[r] && !conf_vec[r] && !full_vec[r];
      end
   end

   // Status code of the finished item.
   always_comb begin
      priority if (found) begin
         status_sel = STAT_BOOKED;
      end else if (full_free) begin
         status_sel = STAT_FULL;
      end else begin
         status_sel = STAT_OVERLAP;
      end
   end

   // Sequencer state and slot counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Response payload register; the room index is reported in two bits.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_tdata_ff <= {4'd0, (found ? 2'(pick_idx) : 2'd0), status_sel};
      end
   end

   // Next state and sequencer controls.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      req_tready    = 1'b0;
      commit        = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            addr_in    = '0;
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_SLOT) begin
               addr_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + SLOT_AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Wait until the output register is free, then book and respond.
            if (!rsp_tvalid_ff || rsp_tready) begin
               commit        = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[src/ffira_checker.sv]
// ----------------------------------------------------------------------------
// ffira_checker
// Port-level checks for the first-fit interval room allocator.
// ----------------------------------------------------------------------------
module ffira_checker
   import ffira_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // A response never carries the unused status code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != STAT_UNUSED))
      else $error("response status code is out of range");

   // Only a booked item names a room.
   a_room_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != STAT_BOOKED)) |-> (rsp_tdata[3:2] == 2'd0))
      else $error("room index is nonzero on a refused item");

   // After a request is taken the block is busy with it.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one is in work");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind first_fit_interval_room_allocator ffira_checker u_ffira_checker (.*);
